FILE: hw/rtl/brlq_pkg.sv
// Shared constants, codes and types for the bitmap run-length query block.
package brlq_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int DEPTH_WORDS_DEF = 1024;

	localparam int FUNC_W = 3;
	localparam int WIDX_W = 10;
	localparam int DATA_W = 64;
	localparam int SIZE_W = 17;
	localparam int LEN_W  = 17;

	// input word layout
	localparam int IN_WIDX_LSB = 0;
	localparam int IN_DATA_LSB = IN_WIDX_LSB + WIDX_W;
	localparam int IN_POS_LSB  = IN_DATA_LSB + DATA_W;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 24;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ONES_FWD  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_ZEROS_FWD = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ONES_REV  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_ZEROS_REV = 3'd4;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIVA = 6'b000010,
		S_DIVB = 6'b000100,
		S_DIVC = 6'b001000,
		S_SCAN = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

endpackage

FILE: hw/rtl/bit_run_length_query.sv
// Bitmap run-length query: word-organized bitmap memory with a word-serial run scanner.
//
// Input words (s_axis) carry a function code in tuser: write one bitmap word, or ask
// for the length of a run of ones or zeros, forward from bit_pos or backward from
// bit_pos - 1. Every input word produces exactly one result word on m_axis: the run
// length and a status flag (1 when the position is beyond the configured size).
// cfg_wen/cfg_wdata set the bitmap size in bits; write it only while the block is idle.
//
// One word is handled at a time. A write, a spare function code or a query that needs no
// scan (out of range, or backward from bit_pos 0) goes from acceptance to S_RESP,
// which loads the result register. A scan first passes S_DIVA, S_DIVB and S_DIVC
// (position and last word index go through a shared multiply-by-reciprocal divider,
// then the first memory read); then the single memory read port walks the run one word
// a cycle, and S_RESP loads the result register. s_axis_tready is high again once it is
// loaded. Reset clears the size register and the control state; bitmap contents are
// undefined until written and get no clearing pass. A stalled m_axis holds the result
// register; the next input word can still be accepted and processed, and it waits before
// the result register until that register is taken.
module bit_run_length_query #(
	parameter int WORD_BITS = brlq_pkg::WORD_BITS_DEF,
	parameter int DEPTH_WORDS = brlq_pkg::DEPTH_WORDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [brlq_pkg::SIZE_W-1:0]           cfg_wdata,     // size_bits
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [brlq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // word_index, word_data, bit_pos
	input  logic [brlq_pkg::FUNC_W-1:0]           s_axis_tuser,  // func
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [brlq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // run_length
	output logic                                  m_axis_tuser   // status
);
	import brlq_pkg::*;

	localparam int AW  = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
	localparam int BW  = $clog2(WORD_BITS);
	localparam int CW  = $clog2(WORD_BITS + 1);
	localparam int XW  = SIZE_W;
	localparam int SH  = XW + BW;
	localparam int MW  = XW + 1;
	localparam int PW  = XW + MW;
	localparam int QW  = PW - SH;
	localparam longint unsigned MULT = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam logic [23:0] CAP = 24'(DEPTH_WORDS * WORD_BITS);

	state_t state_q;

	logic [SIZE_W-1:0]    size_bits_q;
	logic [SIZE_W-1:0]    eff_size;
	logic [WIDX_W-1:0]    in_widx;
	logic [SIZE_W-1:0]    in_pos;
	logic                 in_accept;

	logic                 fwd_q;
	logic                 want_q;
	logic [XW-1:0]        start_x_q;
	logic [PW-1:0]        prod_q;
	logic [XW-1:0]        div_x;
	logic [QW-1:0]        quot;
	logic [XW-1:0]        rem_full;
	logic [AW-1:0]        word_q;
	logic [AW-1:0]        last_q;
	logic [BW-1:0]        bit_q;
	logic [LEN_W-1:0]     len_q;
	logic                 status_q;

	logic [WORD_BITS-1:0] bitmap_q [DEPTH_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 mem_we;

	logic [WORD_BITS-1:0] scan_x;
	logic [CW-1:0]        ones_cnt;
	logic [CW-1:0]        skip;
	logic [CW-1:0]        run;
	logic                 full;
	logic                 cont;
	logic [AW-1:0]        next_word;
	logic [LEN_W:0]       len_sum;
	logic [LEN_W-1:0]     len_next;

	logic                 out_free;
	logic                 m_valid_q;
	logic [LEN_W-1:0]     m_len_q;
	logic                 m_status_q;

	assign in_widx   = s_axis_tdata[IN_WIDX_LSB +: WIDX_W];
	assign in_pos    = s_axis_tdata[IN_POS_LSB +: SIZE_W];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign eff_size = (24'(size_bits_q) > CAP) ? SIZE_W'(CAP) : size_bits_q;

	assign mem_we = in_accept && (s_axis_tuser == FUNC_WRITE) &&
	                (17'(in_widx) < 17'(DEPTH_WORDS));

	// divide by WORD_BITS: exact multiply by rounded-up reciprocal for 17-bit operands
	assign div_x    = (state_q == S_DIVA) ? start_x_q : eff_size - 1'b1;
	assign quot     = prod_q[PW-1:SH];
	assign rem_full = start_x_q - XW'(XW'(quot) * XW'(WORD_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_bits_q <= '0;
		end else if (cfg_wen) begin
			size_bits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_q[AW'(in_widx)] <= s_axis_tdata[IN_DATA_LSB +: WORD_BITS];
		end
		if (rd_en) begin
			rd_data_q <= bitmap_q[rd_addr];
		end
	end

	// run of wanted bits in the current word, counted from the scan start bit
	always_comb begin
		logic [WORD_BITS-1:0] vec;
		logic [WORD_BITS-1:0] x_fwd;
		logic [WORD_BITS-1:0] x_rev;
		logic                 found;
		vec = want_q ? rd_data_q : ~rd_data_q;
		for (int i = 0; i < WORD_BITS; i++) begin
			x_fwd[i] = vec[i] | (i < int'(bit_q));
			x_rev[i] = vec[WORD_BITS-1-i] | ((WORD_BITS - 1 - i) > int'(bit_q));
		end
		scan_x = fwd_q ? x_fwd : x_rev;
		ones_cnt = CW'(WORD_BITS);
		found = 1'b0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!found && !scan_x[i]) begin
				ones_cnt = CW'(i);
				found = 1'b1;
			end
		end
	end

	assign skip      = fwd_q ? CW'(bit_q) : CW'(WORD_BITS - 1) - CW'(bit_q);
	assign run       = ones_cnt - skip;
	assign full      = (ones_cnt == CW'(WORD_BITS));
	assign cont      = full && (fwd_q ? (word_q != last_q) : (word_q != '0));
	assign next_word = fwd_q ? word_q + 1'b1 : word_q - 1'b1;
	assign len_sum   = {1'b0, len_q} + (LEN_W + 1)'(run);
	assign len_next  = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];

	assign rd_en   = (state_q == S_DIVC) || ((state_q == S_SCAN) && cont);
	assign rd_addr = (state_q == S_DIVC) ? word_q : next_word;

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (s_axis_tuser)
							FUNC_ONES_FWD, FUNC_ZEROS_FWD: begin
								state_q <= (in_pos >= eff_size) ? S_RESP : S_DIVA;
							end
							FUNC_ONES_REV, FUNC_ZEROS_REV: begin
								state_q <= (in_pos > eff_size || in_pos == '0) ? S_RESP : S_DIVA;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_DIVA: state_q <= S_DIVB;
				S_DIVB: state_q <= S_DIVC;
				S_DIVC: state_q <= S_SCAN;
				S_SCAN: begin
					if (!cont) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				len_q    <= '0;
				status_q <= STATUS_OK;
				fwd_q    <= (s_axis_tuser == FUNC_ONES_FWD) || (s_axis_tuser == FUNC_ZEROS_FWD);
				want_q   <= (s_axis_tuser == FUNC_ONES_FWD) || (s_axis_tuser == FUNC_ONES_REV);
				if (s_axis_tuser == FUNC_ONES_FWD || s_axis_tuser == FUNC_ZEROS_FWD) begin
					start_x_q <= in_pos;
					if (in_pos >= eff_size) begin
						status_q <= STATUS_RANGE;
					end
				end else begin
					start_x_q <= in_pos - 1'b1;
					if ((s_axis_tuser == FUNC_ONES_REV || s_axis_tuser == FUNC_ZEROS_REV) &&
					    in_pos > eff_size) begin
						status_q <= STATUS_RANGE;
					end
				end
			end
			S_DIVA: begin
				prod_q <= PW'(div_x) * PW'(MW'(MULT));
			end
			S_DIVB: begin
				word_q <= AW'(quot);
				bit_q  <= BW'(rem_full);
				prod_q <= PW'(div_x) * PW'(MW'(MULT));
			end
			S_DIVC: begin
				last_q <= AW'(quot);
			end
			S_SCAN: begin
				len_q <= len_next;
				if (cont) begin
					word_q <= next_word;
					bit_q  <= fwd_q ? '0 : BW'(WORD_BITS - 1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			m_len_q    <= len_q;
			m_status_q <= status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(m_len_q);
	assign m_axis_tuser  = m_status_q;

endmodule

FILE: test/bit_run_length_query_test.sv
// Self-checking testbench for the bitmap run-length query block.
module bit_run_length_query_test;
	import brlq_pkg::*;

	localparam int NWORDS      = DEPTH_WORDS_DEF;
	localparam int WBITS       = WORD_BITS_DEF;
	localparam int CAP_BITS    = NWORDS * WBITS;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 40;

	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [LEN_W-1:0] run_len;
		logic             status;
	} run_result_t;

	// Tracks bitmap contents and size, and the queue of run results still owed.
	class run_tracker;
		logic [WBITS-1:0] bitmap [NWORDS];
		bit               written [NWORDS];
		logic [SIZE_W-1:0] size_bits;
		run_result_t      pending_runs [$];
		int               errors;

		function new();
			size_bits = '0;
			errors = 0;
			foreach (written[i])
				written[i] = 1'b0;
		endfunction

		// blank returns the first never-written word the scan would touch, or -1
		function void scan_run(input logic [FUNC_W-1:0] fn, input logic [SIZE_W-1:0] pos,
				output run_result_t res, output int blank);
			int unsigned eff, lim, p, n;
			bit want;
			eff = (size_bits < CAP_BITS) ? size_bits : CAP_BITS;
			res.run_len = '0;
			res.status = STATUS_OK;
			blank = -1;
			n = 0;
			if (fn == FUNC_ONES_FWD || fn == FUNC_ZEROS_FWD) begin
				want = (fn == FUNC_ONES_FWD);
				if (pos >= eff) begin
					res.status = STATUS_RANGE;
				end else begin
					// padding above size in the last word still counts
					lim = ((eff + WBITS - 1) / WBITS) * WBITS;
					p = pos;
					while (p < lim) begin
						if (!written[p / WBITS]) begin
							blank = p / WBITS;
							break;
						end
						if (p % WBITS == 0 && bitmap[p / WBITS] == {WBITS{want}}) begin
							p += WBITS;
							continue;
						end
						if (bitmap[p / WBITS][p % WBITS] != want)
							break;
						p++;
					end
					n = p - pos;
				end
			end else if (fn == FUNC_ONES_REV || fn == FUNC_ZEROS_REV) begin
				want = (fn == FUNC_ONES_REV);
				if (pos > eff) begin
					res.status = STATUS_RANGE;
				end else begin
					p = pos;
					while (p > 0) begin
						if (!written[(p - 1) / WBITS]) begin
							blank = (p - 1) / WBITS;
							break;
						end
						if (p % WBITS == 0 && bitmap[(p - 1) / WBITS] == {WBITS{want}}) begin
							p -= WBITS;
							continue;
						end
						if (bitmap[(p - 1) / WBITS][(p - 1) % WBITS] != want)
							break;
						p--;
					end
					n = pos - p;
				end
			end
			res.run_len = (n > LEN_MAX) ? LEN_MAX : LEN_W'(n);
		endfunction

		function void note_word(input logic [FUNC_W-1:0] fn, input logic [WIDX_W-1:0] widx,
				input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] pos);
			run_result_t res;
			int blank;
			scan_run(fn, pos, res, blank);
			if (fn == FUNC_WRITE && widx < NWORDS) begin
				bitmap[widx] = data[WBITS-1:0];
				written[widx] = 1'b1;
			end
			pending_runs = {pending_runs, res};
		endfunction

		task report(input string msg);
			if (errors < 50)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_word(input logic [LEN_W-1:0] run_len, input logic status);
			run_result_t want_res;
			if (pending_runs.size() == 0) begin
				report($sformatf("unexpected word run_length=%0d status=%0b", run_len, status));
				return;
			end
			want_res = pending_runs.pop_front();
			if (run_len !== want_res.run_len)
				report($sformatf("run_length %0d, expected %0d", run_len, want_res.run_len));
			if (status !== want_res.status)
				report($sformatf("status %0b, expected %0b", status, want_res.status));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wen;
	logic [SIZE_W-1:0]      cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [FUNC_W-1:0]      s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	logic       hold_req;
	int         burst_left;
	int         quiet_cycles = 0;
	run_tracker runs;

	bit_run_length_query u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly uniform words so that runs cross word boundaries
	function automatic logic [DATA_W-1:0] fill_word();
		int unsigned k;
		k = $urandom_range(1, DATA_W - 1);
		case ($urandom_range(0, 9))
			0, 1, 2: return '0;
			3, 4, 5: return {DATA_W{1'b1}};
			6, 7:    return {$urandom, $urandom};
			8:       return {DATA_W{1'b1}} << k;
			default: return ~({DATA_W{1'b1}} << k);
		endcase
	endfunction

	task automatic push(input logic [FUNC_W-1:0] fn, input logic [WIDX_W-1:0] widx,
			input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] pos);
		logic [IN_TDATA_W-1:0] td;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		td = '0;
		td[IN_WIDX_LSB +: WIDX_W] = widx;
		td[IN_DATA_LSB +: DATA_W] = data;
		td[IN_POS_LSB +: SIZE_W]  = pos;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= td;
		s_axis_tuser  <= fn;
		do @(posedge clk); while (!s_axis_tready);
		runs.note_word(fn, widx, data, pos);
	endtask

	// fills any never-written word the query would read, then sends it
	task automatic issue(input logic [FUNC_W-1:0] fn, input logic [WIDX_W-1:0] widx,
			input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] pos);
		run_result_t res;
		int blank;
		runs.scan_run(fn, pos, res, blank);
		while (blank >= 0) begin
			push(FUNC_WRITE, WIDX_W'(blank), fill_word(), SIZE_W'($urandom));
			runs.scan_run(fn, pos, res, blank);
		end
		push(fn, widx, data, pos);
	endtask

	task automatic query(input logic [FUNC_W-1:0] fn, input int unsigned pos);
		issue(fn, WIDX_W'($urandom), {$urandom, $urandom}, SIZE_W'(pos));
	endtask

	task automatic write_word(input int unsigned widx, input logic [DATA_W-1:0] data);
		issue(FUNC_WRITE, WIDX_W'(widx), data, SIZE_W'($urandom));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (runs.pending_runs.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_size(input int unsigned value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wdata <= SIZE_W'(value);
		cfg_wen   <= 1'b1;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		runs.size_bits = SIZE_W'(value);
	endtask

	task automatic random_item();
		logic [FUNC_W-1:0] fn;
		logic [WIDX_W-1:0] widx;
		int unsigned eff, nw, pick, pos;
		eff = (runs.size_bits < CAP_BITS) ? runs.size_bits : CAP_BITS;
		nw = (eff + WBITS - 1) / WBITS;
		pick = $urandom_range(0, 99);
		if (pick < 28)
			fn = FUNC_WRITE;
		else if (pick < 33)
			fn = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
		else
			fn = FUNC_W'($urandom_range(FUNC_ONES_FWD, FUNC_ZEROS_REV));
		if (nw > 0 && $urandom_range(0, 4) != 0)
			widx = WIDX_W'($urandom_range(0, nw - 1));
		else
			widx = WIDX_W'($urandom);
		case ($urandom_range(0, 9))
			7:       pos = (eff > 0) ? eff - 1 : 0;
			8:       pos = eff + $urandom_range(0, 1);
			9:       pos = $urandom_range(0, (1 << SIZE_W) - 1);
			default: pos = $urandom_range(0, eff);
		endcase
		issue(fn, widx, fill_word(), SIZE_W'(pos));
	endtask

	// receiver: changing stall patterns, plus one long hold on request
	initial begin
		int mode, left, cyc, period, duty;
		bit rdy;
		bit held;
		m_axis_tready = 1'b0;
		mode = 0;
		left = 0;
		cyc = 0;
		period = 2;
		duty = 1;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
					period = $urandom_range(2, 9);
					duty = $urandom_range(1, period - 1);
				end
				left--;
				cyc++;
				case (mode)
					0:       rdy = 1'b1;
					1:       rdy = $urandom_range(0, 1);
					2:       rdy = (cyc % period) < duty;
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
				m_axis_tready <= rdy;
			end
		end
	end

	// result checking and watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				runs.check_word(m_axis_tdata[LEN_W-1:0], m_axis_tuser);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned sizes [10];
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_WRITE;
		hold_req = 1'b0;
		burst_left = 0;
		runs = new();
		sizes = '{0, 1, 64, 65, 777, 4096, 65535, 65536, (1 << SIZE_W) - 1, 0};
		sizes[9] = $urandom_range(2, 20000);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size still at its reset value of zero
		query(FUNC_ONES_FWD, 0);
		query(FUNC_ZEROS_REV, 0);
		query(FUNC_ONES_REV, 1);
		query(FUNC_SPARE_LO, 0);
		query(FUNC_SPARE_LO + 3'd1, 65536);
		query(FUNC_SPARE_HI, (1 << SIZE_W) - 1);

		// three words in use, padding above bit 129 counted going forward
		set_size(130);
		write_word(0, {DATA_W{1'b1}});
		write_word(1, {DATA_W{1'b1}});
		write_word(2, 64'hF);
		query(FUNC_ONES_FWD, 0);
		query(FUNC_ONES_FWD, 129);
		query(FUNC_ZEROS_FWD, 0);
		query(FUNC_ONES_FWD, 130);
		query(FUNC_ONES_REV, 128);
		query(FUNC_ONES_REV, 130);
		query(FUNC_ZEROS_REV, 131);

		// size above capacity saturates
		set_size((1 << SIZE_W) - 1);
		write_word(NWORDS - 1, 64'h8000_0000_0000_0000);
		query(FUNC_ONES_FWD, CAP_BITS - 1);
		query(FUNC_ONES_REV, CAP_BITS);
		query(FUNC_ZEROS_FWD, CAP_BITS);
		query(FUNC_ZEROS_REV, (1 << SIZE_W) - 1);

		foreach (sizes[ph]) begin
			set_size(sizes[ph]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (sizes[ph] == 4096 && i == 10)
					hold_req <= 1'b1;
				random_item();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (runs.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
